FILE: hdl/euler_to_quaternion_macros.svh
// ----------------------------------------------------------------------------
// Euler to quaternion assertion macros
// Shared concurrent assertion forms for the checker of the converter.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define E2Q_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("e2q: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define E2Q_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("e2q: next-cycle check failed");

`endif

FILE: hdl/e2q_pkg.sv
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Payload types, fixed widths, constants and the sine series used to build
// the quarter-wave table.
// ----------------------------------------------------------------------------
package e2q_pkg;

   localparam int SINE_TABLE_DEPTH_DEFAULT = 1024;
   localparam int ANGLE_W = 16;
   localparam int QUAT_W = 16;
   localparam int MAG_W = 16;
   localparam int TRIG_W = MAG_W + 1;

   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint DEG_UNITS = 64'sd11520;
   localparam longint SERIES_DIV [10] = '{6, 20, 42, 72, 110, 156, 210, 272, 342, 420};

   typedef struct packed {
      logic signed [ANGLE_W-1:0] roll_angle;
      logic signed [ANGLE_W-1:0] pitch_angle;
      logic signed [ANGLE_W-1:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } rsp_type;

   typedef struct packed {
      logic sin_neg;
      logic cos_neg;
   } trig_sign_type;

   // Sine of a Q30 angle in radians, rounded to a Q1.15 magnitude in 0..32768.
   function automatic logic [MAG_W-1:0] sine_series(input longint x);
      longint x2;
      longint term;
      longint sum;
      longint q;
      int n;
      x2 = (x * x) >>> 30;
      term = x;
      sum = x;
      for (n = 0; n < 10; n++) begin
         term = ((term * x2) >>> 30) / SERIES_DIV[n];
         if (n[0] == 1'b0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      q = (sum + (longint'(1) <<< 14)) >>> 15;
      if (q > (longint'(1) <<< 15)) begin
         q = longint'(1) <<< 15;
      end
      return MAG_W'(q);
   endfunction

endpackage

FILE: hdl/e2q_phase.sv
// ----------------------------------------------------------------------------
// Euler to quaternion phase stages
// Three pipeline stages that turn each angle into a table phase, then into
// quarter-wave addresses and signs for its sine and cosine.
// ----------------------------------------------------------------------------
module e2q_phase #(
   parameter int Depth = e2q_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic [2:0]                  en,
   input  e2q_pkg::req_type            req_data,
   output logic [$clog2(Depth+1)-1:0]  sin_addr [3],
   output logic [$clog2(Depth+1)-1:0]  cos_addr [3],
   output e2q_pkg::trig_sign_type      trig_sign [3]
);
   import e2q_pkg::*;

   localparam int AW = $clog2(Depth + 1);
   localparam int LOG_D = $clog2(Depth);
   localparam int N_W = ANGLE_W + LOG_D + 2;
   localparam int DIV_SHIFT = 9;
   localparam longint DIV_ODD = (2 * DEG_UNITS) / (longint'(1) <<< DIV_SHIFT);
   localparam int U_W = LOG_D + DIV_SHIFT;
   localparam int QUO_SHIFT = U_W + 6;
   localparam int R_W = U_W + 1;
   localparam int P_W = U_W + R_W;
   localparam int QS_W = P_W - QUO_SHIFT + 1;
   localparam int PH_W = LOG_D + 3;
   localparam longint BIAS_Q = 4 * longint'(Depth);
   localparam longint RECIP = ((longint'(1) <<< QUO_SHIFT) + DIV_ODD - 1) / DIV_ODD;

   localparam logic signed [N_W-1:0] TWO_D_N = N_W'(2 * longint'(Depth));
   localparam logic signed [N_W-1:0] ROUND_N = N_W'(DEG_UNITS);
   localparam logic signed [N_W-1:0] BIAS_N = N_W'(DIV_ODD * BIAS_Q);
   localparam logic [R_W-1:0] RECIP_R = R_W'(RECIP);
   localparam logic signed [QS_W-1:0] BIAS_QS = QS_W'(BIAS_Q);
   localparam logic signed [PH_W-1:0] ZERO_P = '0;
   localparam logic signed [PH_W-1:0] D1_P = PH_W'(Depth);
   localparam logic signed [PH_W-1:0] D2_P = PH_W'(2 * Depth);
   localparam logic signed [PH_W-1:0] D3_P = PH_W'(3 * Depth);
   localparam logic [AW-1:0] D_A = AW'(Depth);

   logic signed [ANGLE_W-1:0] angle [3];
   logic signed [N_W-1:0] num [3];
   logic signed [N_W-1:0] scaled [3];
   logic [U_W-1:0] biased_in [3];
   logic [U_W-1:0] biased_ff [3];
   logic [P_W-1:0] prod [3];
   logic [QS_W-2:0] quot [3];
   logic signed [PH_W-1:0] phase_in [3];
   logic signed [PH_W-1:0] phase_ff [3];
   logic [2:0] span [3];
   logic signed [PH_W-1:0] offset [3];
   logic [AW-1:0] rem [3];
   logic [1:0] sin_quad [3];
   logic [1:0] cos_quad [3];
   logic [AW-1:0] sin_addr_in [3];
   logic [AW-1:0] sin_addr_ff [3];
   logic [AW-1:0] cos_addr_in [3];
   logic [AW-1:0] cos_addr_ff [3];
   trig_sign_type sign_in [3];
   trig_sign_type sign_ff [3];

   assign angle[0] = req_data.roll_angle;
   assign angle[1] = req_data.pitch_angle;
   assign angle[2] = req_data.yaw_angle;

   // The half angle in table steps is floor((2 v D + 11520) / 23040); the divide
   // is a shift by 512 followed by a reciprocal multiply for the factor 45.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = N_W'(angle[i]) * TWO_D_N + ROUND_N;
         scaled[i] = num[i] >>> DIV_SHIFT;
         biased_in[i] = U_W'(scaled[i] + BIAS_N);

         prod[i] = P_W'(biased_ff[i]) * P_W'(RECIP_R);
         quot[i] = prod[i][P_W-1:QUO_SHIFT];
         phase_in[i] = PH_W'($signed({1'b0, quot[i]}) - BIAS_QS);

         span[i] = 3'(phase_ff[i] >= -D2_P) + 3'(phase_ff[i] >= -D1_P)
                 + 3'(phase_ff[i] >= ZERO_P) + 3'(phase_ff[i] >= D1_P)
                 + 3'(phase_ff[i] >= D2_P);
         case (span[i])
            3'd0: begin
               offset[i] = D3_P;
            end
            3'd1: begin
               offset[i] = D2_P;
            end
            3'd2: begin
               offset[i] = D1_P;
            end
            3'd4: begin
               offset[i] = -D1_P;
            end
            3'd5: begin
               offset[i] = -D2_P;
            end
            default: begin
               offset[i] = '0;
            end
         endcase
         rem[i] = AW'(phase_ff[i] + offset[i]);
         sin_quad[i] = 2'(span[i] + 3'd1);
         cos_quad[i] = 2'(span[i] + 3'd2);
         sin_addr_in[i] = sin_quad[i][0] ? D_A - rem[i] : rem[i];
         cos_addr_in[i] = cos_quad[i][0] ? D_A - rem[i] : rem[i];
         sign_in[i].sin_neg = sin_quad[i][1];
         sign_in[i].cos_neg = cos_quad[i][1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (en[0]) begin
            biased_ff[i] <= biased_in[i];
         end
         if (en[1]) begin
            phase_ff[i] <= phase_in[i];
         end
         if (en[2]) begin
            sin_addr_ff[i] <= sin_addr_in[i];
            cos_addr_ff[i] <= cos_addr_in[i];
            sign_ff[i] <= sign_in[i];
         end
      end
   end

   assign sin_addr = sin_addr_ff;
   assign cos_addr = cos_addr_ff;
   assign trig_sign = sign_ff;

endmodule

FILE: hdl/e2q_sine_rom.sv
// ----------------------------------------------------------------------------
// Euler to quaternion sine table
// Quarter-wave sine magnitudes with two registered read ports.
// ----------------------------------------------------------------------------
module e2q_sine_rom #(
   parameter int Depth = e2q_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [$clog2(Depth+1)-1:0]  addr_a,
   input  logic [$clog2(Depth+1)-1:0]  addr_b,
   output logic [e2q_pkg::MAG_W-1:0]   data_a,
   output logic [e2q_pkg::MAG_W-1:0]   data_b
);
   import e2q_pkg::*;

   typedef logic [MAG_W-1:0] rom_type [Depth+1];

   function automatic rom_type build_rom();
      rom_type rom;
      longint x;
      int k;
      for (k = 0; k <= Depth; k++) begin
         x = (longint'(k) * HALF_PI_Q30 + longint'(Depth / 2)) / Depth;
         rom[k] = sine_series(x);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [MAG_W-1:0] data_a_ff;
   logic [MAG_W-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         data_a_ff <= SINE_ROM[addr_a];
         data_b_ff <= SINE_ROM[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

FILE: hdl/e2q_combine.sv
// ----------------------------------------------------------------------------
// Euler to quaternion product stages
// Signs the table values, forms the pair and triple products, then rounds
// and saturates the four negated quaternion components.
// ----------------------------------------------------------------------------
module e2q_combine (
   input  logic                          clock,
   input  logic [4:0]                    en,
   input  logic [e2q_pkg::MAG_W-1:0]     sin_mag [3],
   input  logic [e2q_pkg::MAG_W-1:0]     cos_mag [3],
   input  e2q_pkg::trig_sign_type        trig_sign [3],
   output e2q_pkg::rsp_type              rsp_data
);
   import e2q_pkg::*;

   localparam int PAIR_W = 2 * TRIG_W - 2;
   localparam int P3_W = PAIR_W + TRIG_W - 1;
   localparam int ACC_W = P3_W + 1;
   localparam int ROUND_SHIFT = 30;
   localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(longint'(1) <<< (ROUND_SHIFT - 1));
   localparam logic signed [ACC_W:0] Q_MAX = (ACC_W+1)'((longint'(1) <<< (QUAT_W - 1)) - 1);
   localparam logic signed [ACC_W:0] Q_MIN = (ACC_W+1)'(-(longint'(1) <<< (QUAT_W - 1)));

   trig_sign_type sign_s4_ff [3];
   logic signed [TRIG_W-1:0] sv_in [3];
   logic signed [TRIG_W-1:0] cv_in [3];
   logic signed [TRIG_W-1:0] sv_ff [3];
   logic signed [TRIG_W-1:0] cv_ff [3];
   logic signed [TRIG_W-1:0] yaw_s_ff;
   logic signed [TRIG_W-1:0] yaw_c_ff;
   logic signed [PAIR_W-1:0] pcc_ff;
   logic signed [PAIR_W-1:0] pss_ff;
   logic signed [PAIR_W-1:0] psc_ff;
   logic signed [PAIR_W-1:0] pcs_ff;
   logic signed [P3_W-1:0] w1_ff;
   logic signed [P3_W-1:0] w2_ff;
   logic signed [P3_W-1:0] x1_ff;
   logic signed [P3_W-1:0] x2_ff;
   logic signed [P3_W-1:0] y1_ff;
   logic signed [P3_W-1:0] y2_ff;
   logic signed [P3_W-1:0] z1_ff;
   logic signed [P3_W-1:0] z2_ff;
   logic signed [ACC_W-1:0] acc_w;
   logic signed [ACC_W-1:0] acc_x;
   logic signed [ACC_W-1:0] acc_y;
   logic signed [ACC_W-1:0] acc_z;
   rsp_type rsp_in;
   rsp_type rsp_ff;

   // Negates the sum, rounds half up to Q1.15 and clamps to the output range.
   function automatic logic signed [QUAT_W-1:0] sat_round(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W:0] biased;
      logic signed [ACC_W:0] shifted;
      biased = RND_HALF - (ACC_W+1)'(acc);
      shifted = biased >>> ROUND_SHIFT;
      if (shifted > Q_MAX) begin
         shifted = Q_MAX;
      end else if (shifted < Q_MIN) begin
         shifted = Q_MIN;
      end
      return QUAT_W'(shifted);
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sv_in[i] = sign_s4_ff[i].sin_neg ? -$signed({1'b0, sin_mag[i]})
                                          : $signed({1'b0, sin_mag[i]});
         cv_in[i] = sign_s4_ff[i].cos_neg ? -$signed({1'b0, cos_mag[i]})
                                          : $signed({1'b0, cos_mag[i]});
      end
      acc_w = ACC_W'(w1_ff) + ACC_W'(w2_ff);
      acc_x = ACC_W'(x1_ff) - ACC_W'(x2_ff);
      acc_y = ACC_W'(y1_ff) + ACC_W'(y2_ff);
      acc_z = ACC_W'(z1_ff) - ACC_W'(z2_ff);
      rsp_in.quat_w = sat_round(acc_w);
      rsp_in.quat_x = sat_round(acc_x);
      rsp_in.quat_y = sat_round(acc_y);
      rsp_in.quat_z = sat_round(acc_z);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sign_s4_ff <= trig_sign;
      end
      if (en[1]) begin
         sv_ff <= sv_in;
         cv_ff <= cv_in;
      end
      if (en[2]) begin
         pcc_ff <= PAIR_W'(cv_ff[0] * cv_ff[1]);
         pss_ff <= PAIR_W'(sv_ff[0] * sv_ff[1]);
         psc_ff <= PAIR_W'(sv_ff[0] * cv_ff[1]);
         pcs_ff <= PAIR_W'(cv_ff[0] * sv_ff[1]);
         yaw_s_ff <= sv_ff[2];
         yaw_c_ff <= cv_ff[2];
      end
      if (en[3]) begin
         w1_ff <= P3_W'(pcc_ff * yaw_c_ff);
         w2_ff <= P3_W'(pss_ff * yaw_s_ff);
         x1_ff <= P3_W'(psc_ff * yaw_c_ff);
         x2_ff <= P3_W'(pcs_ff * yaw_s_ff);
         y1_ff <= P3_W'(pcs_ff * yaw_c_ff);
         y2_ff <= P3_W'(psc_ff * yaw_s_ff);
         z1_ff <= P3_W'(pcc_ff * yaw_s_ff);
         z2_ff <= P3_W'(pss_ff * yaw_c_ff);
      end
      if (en[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/euler_to_quaternion.sv
// ----------------------------------------------------------------------------
// Euler angles to quaternion converter
// Each request carries roll, pitch and yaw in signed Q10.6 degrees; each
// response carries the quaternion w, x, y, z in signed Q1.15, saturated.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low. Every request gives exactly one response.
// The datapath is an eight stage pipeline: phase scaling, reciprocal divide,
// quadrant fold, table read, signing, pair products, triple products, and
// round with saturate. While rsp_stall is low, one request per cycle is
// sustained; a stage advances whenever the stage after it is empty or
// advancing, so bubbles close up under a stall.
// While the response is stalled it holds, and requests are still taken
// until every stage is full; then req_stall rises.
// Synchronous reset empties the pipeline; the sine table is constant.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
   parameter int SINE_TABLE_DEPTH = e2q_pkg::SINE_TABLE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  e2q_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output e2q_pkg::rsp_type   rsp_data
);
   import e2q_pkg::*;

   localparam int STAGES = 8;
   localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

   logic [STAGES:1] valid_ff;
   logic [STAGES:1] valid_in;
   logic [STAGES:1] en;
   logic [AW-1:0] sin_addr [3];
   logic [AW-1:0] cos_addr [3];
   trig_sign_type trig_sign [3];
   logic [MAG_W-1:0] sin_mag [3];
   logic [MAG_W-1:0] cos_mag [3];

   always_comb begin
      en[STAGES] = !valid_ff[STAGES] || !rsp_stall;
      for (int i = STAGES - 1; i >= 1; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[1] = en[1] ? req_valid : valid_ff[1];
      for (int i = 2; i <= STAGES; i++) begin
         valid_in[i] = en[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[1];
   assign rsp_valid = valid_ff[STAGES];

   e2q_phase #(
      .Depth     (SINE_TABLE_DEPTH)
   ) u_phase (
      .clock     (clock),
      .en        (en[3:1]),
      .req_data  (req_data),
      .sin_addr  (sin_addr),
      .cos_addr  (cos_addr),
      .trig_sign (trig_sign)
   );

   for (genvar g = 0; g < 3; g++) begin : g_rom
      e2q_sine_rom #(
         .Depth  (SINE_TABLE_DEPTH)
      ) u_rom (
         .clock  (clock),
         .en     (en[4]),
         .addr_a (sin_addr[g]),
         .addr_b (cos_addr[g]),
         .data_a (sin_mag[g]),
         .data_b (cos_mag[g])
      );
   end

   e2q_combine u_combine (
      .clock     (clock),
      .en        (en[8:4]),
      .sin_mag   (sin_mag),
      .cos_mag   (cos_mag),
      .trig_sign (trig_sign),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/e2q_checker.sv
// ----------------------------------------------------------------------------
// Euler to quaternion port checker
// Watches the converter ports for reset, response hold and back pressure.
// ----------------------------------------------------------------------------
`include "euler_to_quaternion_macros.svh"

module e2q_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  e2q_pkg::rsp_type   rsp_data
);
   import e2q_pkg::*;

   `E2Q_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)
   `E2Q_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `E2Q_ASSERT_IMPLY(a_stall_from_output, clock, reset, req_stall, rsp_valid && rsp_stall)
   `E2Q_ASSERT_NEXT(a_full_flows, clock, reset, req_valid && !req_stall && !rsp_stall, !req_stall || rsp_stall)

endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (.*);

FILE: tb/euler_to_quaternion_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler to quaternion converter testbench
// Sends roll, pitch and yaw requests through the valid/stall handshake while
// both sides idle and stall at random. A scoreboard rebuilds the quarter-wave
// sine table, predicts the saturated Q1.15 quaternion of every accepted
// request, and checks each response against the oldest prediction.
// ----------------------------------------------------------------------------
module euler_to_quaternion_tb;
   import e2q_pkg::*;

   typedef struct {
      req_type angles;
      rsp_type quat;
   } quat_expectation_type;

   class quat_scoreboard_type;
      localparam int DEPTH = SINE_TABLE_DEPTH_DEFAULT;
      quat_expectation_type pending_quats[$];
      longint quarter_sine[];
      int mismatches;

      function new();
         longint x;
         longint x2;
         longint term;
         longint acc;
         longint q;
         int k;
         int n;
         mismatches = 0;
         quarter_sine = new[DEPTH + 1];
         for (k = 0; k <= DEPTH; k++) begin
            x = (longint'(k) * HALF_PI_Q30 + DEPTH / 2) / DEPTH;
            x2 = (x * x) >>> 30;
            term = x;
            acc = x;
            for (n = 1; n <= 10; n++) begin
               term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  acc = acc - term;
               end else begin
                  acc = acc + term;
               end
            end
            if (acc < 0) begin
               acc = 0;
            end
            q = (acc + (longint'(1) <<< 14)) >>> 15;
            if (q > 32768) begin
               q = 32768;
            end
            quarter_sine[k] = q;
         end
      endfunction

      function longint phase_of(logic signed [ANGLE_W-1:0] angle);
         longint num;
         longint den;
         num = 2 * longint'(angle) * DEPTH + DEG_UNITS;
         den = 2 * DEG_UNITS;
         if (num >= 0) begin
            return num / den;
         end
         return -((-num + den - 1) / den);
      endfunction

      function longint sine_of(longint phase);
         longint ring;
         longint p;
         longint r;
         ring = 4 * DEPTH;
         p = phase % ring;
         if (p < 0) begin
            p = p + ring;
         end
         r = p % DEPTH;
         case (p / DEPTH)
            0: begin
               return quarter_sine[r];
            end
            1: begin
               return quarter_sine[DEPTH - r];
            end
            2: begin
               return -quarter_sine[r];
            end
            default: begin
               return -quarter_sine[DEPTH - r];
            end
         endcase
      endfunction

      function logic [QUAT_W-1:0] round_negated(longint acc);
         longint r;
         r = (-acc + (longint'(1) <<< 29)) >>> 30;
         if (r > 32767) begin
            r = 32767;
         end
         if (r < -32768) begin
            r = -32768;
         end
         return QUAT_W'(r);
      endfunction

      function rsp_type convert_angles(req_type angles);
         longint pa;
         longint pb;
         longint pc;
         longint sa;
         longint ca;
         longint sb;
         longint cb;
         longint sc;
         longint cc;
         rsp_type quat;
         pa = phase_of(angles.roll_angle);
         pb = phase_of(angles.pitch_angle);
         pc = phase_of(angles.yaw_angle);
         sa = sine_of(pa);
         ca = sine_of(pa + DEPTH);
         sb = sine_of(pb);
         cb = sine_of(pb + DEPTH);
         sc = sine_of(pc);
         cc = sine_of(pc + DEPTH);
         quat.quat_w = round_negated(ca * cb * cc + sa * sb * sc);
         quat.quat_x = round_negated(sa * cb * cc - ca * sb * sc);
         quat.quat_y = round_negated(ca * sb * cc + sa * cb * sc);
         quat.quat_z = round_negated(ca * cb * sc - sa * sb * cc);
         return quat;
      endfunction

      function void note_request(req_type angles);
         quat_expectation_type item;
         item.angles = angles;
         item.quat = convert_angles(angles);
         pending_quats = {pending_quats, item};
      endfunction

      function int outstanding();
         return pending_quats.size();
      endfunction

      task report(string msg);
         if (mismatches < 40) begin
            $display("%0t ns: %s", $time, msg);
         end
         mismatches++;
      endtask

      task compare_field(string field, quat_expectation_type item,
                         logic signed [QUAT_W-1:0] got, logic signed [QUAT_W-1:0] want);
         if (got !== want) begin
            report($sformatf("%s got %0d expected %0d for angles %0d %0d %0d", field, got,
                             want, item.angles.roll_angle, item.angles.pitch_angle,
                             item.angles.yaw_angle));
         end
      endtask

      task check_response(rsp_type got);
         quat_expectation_type item;
         if (pending_quats.size() == 0) begin
            report("response arrived with no request outstanding");
         end else begin
            item = pending_quats.pop_front();
            compare_field("quat_w", item, got.quat_w, item.quat.quat_w);
            compare_field("quat_x", item, got.quat_x, item.quat.quat_x);
            compare_field("quat_y", item, got.quat_y, item.quat.quat_y);
            compare_field("quat_z", item, got.quat_z, item.quat.quat_z);
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   quat_scoreboard_type sb;
   int idle_level = 0;
   int unsigned stall_left = 0;

   euler_to_quaternion uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   function automatic int unsigned idle_cycles();
      int unsigned r;
      if (idle_level == 0) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      if (r < 97 || idle_level == 1) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ANGLE_W-1:0] random_angle();
      int unsigned style;
      int offset;
      style = $urandom_range(0, 9);
      if (style < 5) begin
         return ANGLE_W'($urandom_range(0, 65535));
      end
      if (style < 8) begin
         return ANGLE_W'(int'($urandom_range(0, 46080)) - 23040);
      end
      offset = int'($urandom_range(0, 6)) - 3;
      return ANGLE_W'((int'($urandom_range(0, 10)) - 5) * 5760 + offset);
   endfunction

   task automatic send_angles(input req_type angles);
      int unsigned gap;
      req_data <= angles;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(angles);
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_triplet(input int roll, input int pitch, input int yaw);
      req_type angles;
      angles.roll_angle = ANGLE_W'(roll);
      angles.pitch_angle = ANGLE_W'(pitch);
      angles.yaw_angle = ANGLE_W'(yaw);
      send_angles(angles);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      req_type angles;
      repeat (count) begin
         angles.roll_angle = random_angle();
         angles.pitch_angle = random_angle();
         angles.yaw_angle = random_angle();
         send_angles(angles);
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= idle_cycles();
         rsp_stall <= (idle_cycles() > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
      end
   end

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_triplet(0, 0, 0);
      send_triplet(32767, 32767, 32767);
      send_triplet(-32768, -32768, -32768);
      send_triplet(32767, -32768, 0);
      send_triplet(-1, 1, -1);
      send_triplet(5, 6, -6);
      send_triplet(5760, 0, 0);
      send_triplet(0, 5760, 0);
      send_triplet(0, 0, 5760);
      send_triplet(11520, 0, 0);
      send_triplet(0, -11520, 0);
      send_triplet(23040, 0, 0);
      send_triplet(23040, 23040, 23040);
      send_triplet(-23040, 0, 23040);
      send_triplet(2880, 2880, 2880);
      send_triplet(5760, 5760, 5760);
      send_triplet(-5760, 11520, -17280);
      send_triplet(17280, 17280, 17280);
      send_triplet(32767, 0, -32768);
      send_triplet(30000, -30000, 12345);
      send_triplet(-11520, -5760, 28800);
      drain_results();

      send_random(400);
      drain_results();
      idle_level = 1;
      send_random(600);
      drain_results();
      idle_level = 2;
      send_random(900);
      drain_results();

      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
